// File: hw/rtl/mi3_pkg.sv
// Shared types, widths and index tables for the 3x3 matrix inverse block.
package mi3_pkg;

  localparam int unsigned IN_W   = 16;             // Q4.12 entry width
  localparam int unsigned IN_FRAC = IN_W - 4;
  localparam int unsigned OUT_W  = 32;             // Q16.16 entry width
  localparam int unsigned OUT_FRAC = OUT_W / 2;
  localparam int unsigned NENT   = 9;
  localparam int unsigned PRD_W  = 2 * IN_W;       // 2x2 minor product
  localparam int unsigned COF_W  = PRD_W + 1;      // cofactor, signed
  localparam int unsigned CMAG_W = PRD_W;          // cofactor magnitude
  localparam int unsigned DET_W  = IN_W + COF_W + 2; // determinant, signed
  localparam int unsigned DMAG_W = DET_W - 1;      // determinant magnitude
  localparam int unsigned SH     = IN_FRAC + OUT_FRAC; // numerator shift
  localparam int unsigned QBITS  = OUT_W;          // quotient bits computed
  localparam int unsigned PRE    = QBITS - SH;     // numerator bits pre-loaded
  localparam int unsigned REM_W  = DMAG_W;
  localparam int unsigned IN_TDATA_W  = NENT * IN_W;
  localparam int unsigned OUT_TDATA_W = NENT * OUT_W;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // tuser bit positions
  localparam int unsigned TU_SINGULAR = 0;
  localparam int unsigned TU_CLIPPED  = 1;

  localparam logic [OUT_W-1:0] POS_CAP = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_CAP = {1'b1, {(OUT_W-1){1'b0}}};

  // Cofactor i = a[X]*a[Y] - a[Z]*a[W] (adjugate, already transposed)
  localparam int unsigned CF_X [NENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned CF_Y [NENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned CF_Z [NENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned CF_W [NENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // Classified item handed from front to back
  typedef struct packed {
    logic [NENT-1:0][CMAG_W-1:0] cmag;
    logic [NENT-1:0]             neg;
    logic [NENT-1:0]             ovf;
    logic [DMAG_W-1:0]           dmag;
    logic                        singular;
  } mi3_item_t;

  function automatic logic signed [PRD_W-1:0] mul_in(input logic signed [IN_W-1:0] x,
                                                     input logic signed [IN_W-1:0] y);
    logic signed [PRD_W-1:0] xe;
    logic signed [PRD_W-1:0] ye;
    xe = PRD_W'(x);
    ye = PRD_W'(y);
    return xe * ye;
  endfunction

endpackage

// File: hw/rtl/mi3_front.sv
// Front: accepts matrices, forms cofactors and determinant, classifies each item.
module mi3_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mi3_pkg::IN_TDATA_W-1:0]     s_tdata,   // a00,a01,a02,a10..a22 from bit 0
  output logic                               push,
  input  logic                               q_ready,
  output mi3_pkg::mi3_item_t                 item
);
  import mi3_pkg::*;

  logic [6:0] v;
  logic       en;

  logic signed [IN_W-1:0]  a   [NENT];
  logic signed [PRD_W-1:0] pp  [NENT];
  logic signed [PRD_W-1:0] pm  [NENT];
  logic signed [IN_W-1:0]  r1  [3];
  logic signed [IN_W-1:0]  r2  [3];
  logic signed [COF_W-1:0] c2  [NENT];
  logic signed [DET_W-1:0] dp  [3];
  logic signed [COF_W-1:0] c3  [NENT];
  logic signed [DET_W-1:0] det;
  logic signed [COF_W-1:0] c4  [NENT];
  logic [CMAG_W-1:0]       cm5 [NENT];
  logic [NENT-1:0]         neg5;
  logic [DMAG_W-1:0]       dm5;
  logic                    sg5;

  // whole front advances together unless the last stage is blocked
  assign en       = !v[6] || q_ready;
  assign s_tready = en;
  assign push     = v[6] && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0: input register
      for (int i = 0; i < NENT; i++) begin
        a[i] <= signed'(s_tdata[i*IN_W +: IN_W]);
      end
      // stage 1: minor products
      for (int i = 0; i < NENT; i++) begin
        pp[i] <= mul_in(a[CF_X[i]], a[CF_Y[i]]);
        pm[i] <= mul_in(a[CF_Z[i]], a[CF_W[i]]);
      end
      for (int j = 0; j < 3; j++) begin
        r1[j] <= a[j];
        r2[j] <= r1[j];
      end
      // stage 2: cofactors
      for (int i = 0; i < NENT; i++) begin
        c2[i] <= COF_W'(pp[i]) - COF_W'(pm[i]);
      end
      // stage 3: first-row expansion products
      dp[0] <= DET_W'(r2[0]) * DET_W'(c2[0]);
      dp[1] <= DET_W'(r2[1]) * DET_W'(c2[3]);
      dp[2] <= DET_W'(r2[2]) * DET_W'(c2[6]);
      c3    <= c2;
      // stage 4: determinant
      det <= dp[0] + dp[1] + dp[2];
      c4  <= c3;
      // stage 5: magnitudes and signs
      for (int i = 0; i < NENT; i++) begin
        cm5[i]  <= c4[i][COF_W-1] ? CMAG_W'(-c4[i]) : CMAG_W'(c4[i]);
        neg5[i] <= c4[i][COF_W-1] ^ det[DET_W-1];
      end
      dm5 <= det[DET_W-1] ? DMAG_W'(-det) : DMAG_W'(det);
      sg5 <= (det == '0);
      // stage 6: quotient overflow check, q >= 2^QBITS when cmag >= dmag << PRE
      for (int i = 0; i < NENT; i++) begin
        item.cmag[i] <= cm5[i];
        item.ovf[i]  <= ({{(DMAG_W+PRE-CMAG_W){1'b0}}, cm5[i]} >= {dm5, {PRE{1'b0}}});
      end
      item.neg      <= neg5;
      item.dmag     <= dm5;
      item.singular <= sg5;
    end
  end

endmodule

// File: hw/rtl/mi3_queue.sv
// Short register queue between the classifying front and the divider back.
module mi3_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               ready,
  input  mi3_pkg::mi3_item_t wr_item,
  input  logic               pop,
  output logic               empty,
  output mi3_pkg::mi3_item_t rd_item
);
  import mi3_pkg::*;

  mi3_item_t          slot [QDEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [QCNT_W-1:0]  cnt;

  assign ready   = (cnt != QCNT_W'(QDEPTH));
  assign empty   = (cnt == '0);
  assign rd_item = slot[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      cnt <= cnt + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= wr_item;
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt <= QCNT_W'(QDEPTH))
    else $error("queue overfilled");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
      1'b1 |=> cnt == $past(cnt) + QCNT_W'($past(push)) - QCNT_W'($past(pop)))
    else $error("queue count mismatch");
`endif

endmodule

// File: hw/rtl/mi3_back.sv
// Back: nine pipelined restoring dividers, one quotient bit per stage, then saturation.
module mi3_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_empty,
  output logic                               pop,
  input  mi3_pkg::mi3_item_t                 rd_item,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mi3_pkg::OUT_TDATA_W-1:0]    m_tdata,  // r00,r01,r02,r10..r22 from bit 0
  output logic [mi3_pkg::OUT_TUSER_W-1:0]    m_tuser   // singular, clipped from bit 0
);
  import mi3_pkg::*;

  logic                en;
  logic [QBITS:0]      v;
  logic [REM_W-1:0]    rem  [QBITS+1][NENT];
  logic [QBITS-1:0]    sh   [QBITS+1][NENT];
  logic [DMAG_W-1:0]   dm   [QBITS+1];
  logic [NENT-1:0]     ng   [QBITS+1];
  logic [NENT-1:0]     ov   [QBITS+1];
  logic                sg   [QBITS+1];

  logic [OUT_TDATA_W-1:0] res;
  logic [NENT-1:0]        sat;

  assign en  = !m_tvalid || m_tready;
  assign pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v        <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v        <= {v[QBITS-1:0], !q_empty};
      m_tvalid <= v[QBITS];
    end
  end

  // divider stages: stage 0 loads, each later stage retires one quotient bit
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NENT; l++) begin
        // numerator bits above the computed quotient bits form the starting remainder
        rem[0][l] <= REM_W'(rd_item.cmag[l][CMAG_W-1:QBITS-SH]);
        sh[0][l]  <= {rd_item.cmag[l][QBITS-SH-1:0], {SH{1'b0}}};
      end
      dm[0] <= rd_item.dmag;
      ng[0] <= rd_item.neg;
      ov[0] <= rd_item.ovf;
      sg[0] <= rd_item.singular;
      for (int k = 0; k < QBITS; k++) begin
        for (int l = 0; l < NENT; l++) begin
          if ({rem[k][l], sh[k][l][QBITS-1]} >= {1'b0, dm[k]}) begin
            rem[k+1][l] <= REM_W'({rem[k][l], sh[k][l][QBITS-1]} - {1'b0, dm[k]});
            sh[k+1][l]  <= {sh[k][l][QBITS-2:0], 1'b1};
          end else begin
            rem[k+1][l] <= REM_W'({rem[k][l], sh[k][l][QBITS-1]});
            sh[k+1][l]  <= {sh[k][l][QBITS-2:0], 1'b0};
          end
        end
        dm[k+1] <= dm[k];
        ng[k+1] <= ng[k];
        ov[k+1] <= ov[k];
        sg[k+1] <= sg[k];
      end
    end
  end

  // saturate, apply sign, zero out singular matrices
  always_comb begin
    logic [OUT_W-1:0] cap;
    logic [OUT_W-1:0] mag;
    res = '0;
    sat = '0;
    for (int l = 0; l < NENT; l++) begin
      cap    = ng[QBITS][l] ? NEG_CAP : POS_CAP;
      sat[l] = !sg[QBITS] && (ov[QBITS][l] || (sh[QBITS][l] > cap));
      mag    = sat[l] ? cap : sh[QBITS][l];
      if (!sg[QBITS]) begin
        res[l*OUT_W +: OUT_W] = ng[QBITS][l] ? (~mag + 1'b1) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata              <= res;
      m_tuser[TU_SINGULAR] <= sg[QBITS];
      m_tuser[TU_CLIPPED]  <= |sat;
    end
  end

endmodule

// File: hw/rtl/matrix_inverse_3x3_top.sv
// Stages: 7 front stages, the first loading on the edge that accepts an input item, 1 queue
// slot, 33 divider stages, 1 out. Throughput: one matrix per cycle when nothing stalls;
// each of the nine dividers retires one bit per stage.
// The front and back stall separately; a 4-item queue sits between them.
// Reset (rst, synchronous) clears all valid bits and the queue; payload is not reset.
module matrix_inverse_3x3_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mi3_pkg::IN_TDATA_W-1:0]     s_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mi3_pkg::OUT_TDATA_W-1:0]    m_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22
  output logic [mi3_pkg::OUT_TUSER_W-1:0]    m_tuser    // singular, clipped
);
  import mi3_pkg::*;

  logic      push;
  logic      q_ready;
  logic      pop;
  logic      q_empty;
  mi3_item_t wr_item;
  mi3_item_t rd_item;

  mi3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .push     (push),
    .q_ready  (q_ready),
    .item     (wr_item)
  );

  mi3_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .ready   (q_ready),
    .wr_item (wr_item),
    .pop     (pop),
    .empty   (q_empty),
    .rd_item (rd_item)
  );

  mi3_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .pop      (pop),
    .rd_item  (rd_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
